// ===== hdl/ecd_pkg.sv =====
// Package for the EMA crossover detector: widths, codes, payload and
// controller/datapath command types. No dependencies.
package ecd_pkg;

  localparam int CLOSE_W   = 32;
  localparam int PERIOD_W  = 11;
  localparam int CONF_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_PERIOD = 1024;
  localparam int DEF_FRAC_BITS  = 16;

  localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST = PERIOD_W'(9);
  localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST = PERIOD_W'(21);

  typedef enum logic [1:0] {
    SIG_NONE = 2'd0,
    SIG_BUY  = 2'd1,
    SIG_SELL = 2'd2
  } sig_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAST_PERIOD = 2'd0,
    REG_SLOW_PERIOD = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_SEED = 2'd0,
    OP_UPD  = 2'd1,
    OP_CONF = 2'd2
  } div_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FAST,
    ST_FAST_WAIT,
    ST_SLOW,
    ST_SLOW_WAIT,
    ST_CMP,
    ST_CONF,
    ST_CONF_WAIT,
    ST_RES
  } state_e;

  typedef logic [CLOSE_W-1:0] close_t;

  typedef struct packed {
    sig_e                signal;
    logic [CONF_W-1:0]   confidence;
    logic [CLOSE_W-1:0]  signal_price;
    logic                warmed_up;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [PERIOD_W-1:0]  value;
  } cfg_wr_t;

  typedef struct packed {
    logic    load;
    logic    div_start;
    div_op_e div_op;
    logic    sel_slow;
    logic    avg_wr;
    logic    cmp;
    logic    res_wr;
  } ecd_cmd_t;

  typedef struct packed {
    logic fast_seeded;
    logic fast_due;
    logic slow_seeded;
    logic slow_due;
    logic div_busy;
    logic conf_div;
    logic out_free;
  } ecd_status_t;

endpackage

// ===== hdl/ecd_stream_if.sv =====
// Valid/ready channel carrying one payload item of type T.
// No dependencies; the payload type is set at instantiation.
interface ecd_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/ecd_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module ecd_div #(
  parameter int DW = 58,
  parameter int RW = 49,
  parameter int SW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [RW-1:0] rem_init_i,
  input  logic [RW-1:0] divisor_i,
  input  logic [SW-1:0] steps_i,
  output logic          busy_o,
  output logic [DW-1:0] quot_o
);

  logic          busy_q, busy_d;
  logic [SW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] dq_q, dq_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [RW-1:0] div_q;
  logic [RW-1:0] trial;
  logic          ge;

  // remainder stays below the divisor, so its top bit is always clear
  assign trial = {rem_q[RW-2:0], dq_q[DW-1]};
  assign ge    = (trial >= div_q);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
      dq_d   = dividend_i;
      rem_d  = rem_init_i;
    end else if (busy_q) begin
      dq_d  = {dq_q[DW-2:0], ge};
      rem_d = ge ? (trial - div_q) : trial;
      cnt_d = cnt_q - SW'(1);
      if (cnt_q == SW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = dq_q;

endmodule

// ===== hdl/ecd_dpath.sv =====
// Datapath: period registers, seed sums, both averages, cross compare,
// result register. Depends on ecd_pkg and ecd_div.
module ecd_dpath
  import ecd_pkg::*;
#(
  parameter int MAX_PERIOD = DEF_MAX_PERIOD,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PERIOD_W-1:0]  cfg_val_i,
  input  close_t               close_i,
  input  ecd_cmd_t             cmd_i,
  output ecd_status_t          status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output result_t              out_data_o
);

  localparam int CNT_W = $clog2(MAX_PERIOD + 1);
  localparam int SUM_W = CLOSE_W + $clog2(MAX_PERIOD);
  localparam int AVG_W = CLOSE_W + FRAC_BITS;
  localparam int EW    = (CNT_W > PERIOD_W) ? CNT_W : PERIOD_W;
  localparam int RW    = AVG_W + 1;
  localparam int DW    = SUM_W + FRAC_BITS;
  localparam int SW    = $clog2(DW + 1);

  logic [PERIOD_W-1:0] fast_period_q, slow_period_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [SUM_W-1:0]    fsum_q, ssum_q;
  logic [AVG_W-1:0]    favg_q, savg_q;
  logic                fseed_q, sseed_q, have_prev_q;
  logic                out_valid_q;

  close_t              x_q;
  logic [AVG_W-1:0]    pf_q, ps_q, d_q;
  logic                dir_q;
  sig_e                sig_q;
  logic                warm_q;
  result_t             out_q;

  logic [EW-1:0]       feff, seff, eff_sel;
  logic [SUM_W-1:0]    sum_sel;
  logic [AVG_W-1:0]    avg_sel, xf, diff, q_avg, avg_new;
  logic                dir;
  logic [DW-1:0]       dividend;
  logic [RW-1:0]       rem_init, divisor;
  logic [SW-1:0]       steps;
  logic                div_busy;
  logic [DW-1:0]       quot;
  logic                warm, up, down, out_free;
  logic [CONF_W-1:0]   conf_val;

  function automatic logic [EW-1:0] eff_period(input logic [PERIOD_W-1:0] p);
    logic [EW-1:0] pe;
    pe = EW'(p);
    if (p == '0) begin
      return EW'(1);
    end else if (pe > EW'(MAX_PERIOD)) begin
      return EW'(MAX_PERIOD);
    end
    return pe;
  endfunction

  assign feff    = eff_period(fast_period_q);
  assign seff    = eff_period(slow_period_q);
  assign eff_sel = cmd_i.sel_slow ? seff : feff;
  assign sum_sel = cmd_i.sel_slow ? ssum_q : fsum_q;
  assign avg_sel = cmd_i.sel_slow ? savg_q : favg_q;

  // update step: move the average toward the close by 2*|x-avg|/(p+1)
  assign xf   = {x_q, {FRAC_BITS{1'b0}}};
  assign dir  = (xf >= avg_sel);
  assign diff = dir ? (xf - avg_sel) : (avg_sel - xf);

  always_comb begin
    dividend = '0;
    rem_init = '0;
    divisor  = RW'(savg_q);
    steps    = SW'(CONF_W);
    case (cmd_i.div_op)
      OP_SEED: begin
        dividend = {sum_sel, {FRAC_BITS{1'b0}}};
        divisor  = RW'(cnt_q);
        steps    = SW'(DW);
      end
      OP_UPD: begin
        dividend = DW'({diff, 1'b0}) << (DW - RW);
        divisor  = RW'(eff_sel) + RW'(1);
        steps    = SW'(RW);
      end
      OP_CONF: begin
        rem_init = RW'(d_q);
      end
      default: begin
        dividend = '0;
      end
    endcase
  end

  ecd_div #(
    .DW (DW),
    .RW (RW),
    .SW (SW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .rem_init_i (rem_init),
    .divisor_i  (divisor),
    .steps_i    (steps),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign q_avg   = quot[AVG_W-1:0];
  assign avg_new = (cmd_i.div_op == OP_SEED) ? q_avg :
                   dir_q ? (avg_sel + q_avg) : (avg_sel - q_avg);

  assign warm = fseed_q && sseed_q;
  assign up   = (pf_q <= ps_q) && (favg_q > savg_q);
  assign down = (pf_q >= ps_q) && (favg_q < savg_q);

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    if ((sig_q == SIG_NONE) || (savg_q == '0)) begin
      conf_val = '0;
    end else if (d_q >= savg_q) begin
      conf_val = '1;
    end else begin
      conf_val = quot[CONF_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_period_q <= FAST_PERIOD_RST;
      slow_period_q <= SLOW_PERIOD_RST;
      cnt_q         <= '0;
      fsum_q        <= '0;
      ssum_q        <= '0;
      favg_q        <= '0;
      savg_q        <= '0;
      fseed_q       <= 1'b0;
      sseed_q       <= 1'b0;
      have_prev_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_FAST_PERIOD) begin
          fast_period_q <= cfg_val_i;
        end else if (cfg_idx_i == REG_SLOW_PERIOD) begin
          slow_period_q <= cfg_val_i;
        end
      end
      if (cmd_i.load) begin
        if (cnt_q < CNT_W'(MAX_PERIOD)) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
        // accumulate only while seeding
        if (!fseed_q) begin
          fsum_q <= fsum_q + SUM_W'(close_i);
        end
        if (!sseed_q) begin
          ssum_q <= ssum_q + SUM_W'(close_i);
        end
      end
      if (cmd_i.avg_wr) begin
        if (cmd_i.sel_slow) begin
          savg_q <= avg_new;
          if (cmd_i.div_op == OP_SEED) begin
            sseed_q <= 1'b1;
          end
        end else begin
          favg_q <= avg_new;
          if (cmd_i.div_op == OP_SEED) begin
            fseed_q <= 1'b1;
          end
        end
      end
      if (cmd_i.cmp && warm) begin
        have_prev_q <= 1'b1;
      end
      if (cmd_i.res_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q  <= close_i;
      pf_q <= favg_q;
      ps_q <= savg_q;
    end
    if (cmd_i.div_start) begin
      dir_q <= dir;
    end
    if (cmd_i.cmp) begin
      warm_q <= warm;
      d_q    <= (favg_q >= savg_q) ? (favg_q - savg_q) : (savg_q - favg_q);
      if (warm && have_prev_q && up) begin
        sig_q <= SIG_BUY;
      end else if (warm && have_prev_q && down) begin
        sig_q <= SIG_SELL;
      end else begin
        sig_q <= SIG_NONE;
      end
    end
    if (cmd_i.res_wr) begin
      out_q.signal       <= sig_q;
      out_q.confidence   <= conf_val;
      out_q.signal_price <= (sig_q != SIG_NONE) ? x_q : '0;
      out_q.warmed_up    <= warm_q;
    end
  end

  always_comb begin
    status_o             = '0;
    status_o.fast_seeded = fseed_q;
    status_o.fast_due    = !fseed_q && (EW'(cnt_q) >= feff);
    status_o.slow_seeded = sseed_q;
    status_o.slow_due    = !sseed_q && (EW'(cnt_q) >= seff);
    status_o.div_busy    = div_busy;
    status_o.conf_div    = (sig_q != SIG_NONE) && (savg_q != '0) && (d_q < savg_q);
    status_o.out_free    = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/ecd_ctrl.sv =====
// Controller state machine: sequences load, the two average steps, the
// compare, the confidence division and the result write. Depends on ecd_pkg.
module ecd_ctrl
  import ecd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ecd_status_t status_i,
  output ecd_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_FAST;
        end
      end
      ST_FAST: begin
        cmd_o.div_op = status_i.fast_seeded ? OP_UPD : OP_SEED;
        if (status_i.fast_seeded || status_i.fast_due) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_FAST_WAIT;
        end else begin
          state_d = ST_SLOW;
        end
      end
      ST_FAST_WAIT: begin
        cmd_o.div_op = status_i.fast_seeded ? OP_UPD : OP_SEED;
        if (!status_i.div_busy) begin
          cmd_o.avg_wr = 1'b1;
          state_d      = ST_SLOW;
        end
      end
      ST_SLOW: begin
        cmd_o.sel_slow = 1'b1;
        cmd_o.div_op   = status_i.slow_seeded ? OP_UPD : OP_SEED;
        if (status_i.slow_seeded || status_i.slow_due) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_SLOW_WAIT;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_SLOW_WAIT: begin
        cmd_o.sel_slow = 1'b1;
        cmd_o.div_op   = status_i.slow_seeded ? OP_UPD : OP_SEED;
        if (!status_i.div_busy) begin
          cmd_o.avg_wr = 1'b1;
          state_d      = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = ST_CONF;
      end
      ST_CONF: begin
        cmd_o.div_op = OP_CONF;
        if (status_i.conf_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_CONF_WAIT;
        end else begin
          state_d = ST_RES;
        end
      end
      ST_CONF_WAIT: begin
        cmd_o.div_op = OP_CONF;
        if (!status_i.div_busy) begin
          state_d = ST_RES;
        end
      end
      ST_RES: begin
        // hold until the output register is free
        if (status_i.out_free) begin
          cmd_o.res_wr = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/ema_crossover_detector_top.sv =====
// Top level of the EMA crossover detector: controller, datapath and the
// channel interfaces. Depends on ecd_pkg, ecd_stream_if, ecd_ctrl, ecd_dpath.
//
//   channel | dir | payload                                   | accepted when
//   cfg_i   | in  | cfg_wr_t: index, value (period register)  | valid && ready
//   in_i    | in  | close_t: close_price                      | valid && ready
//   out_o   | out | result_t: signal, confidence, price, warm | valid && ready
//
// The controller takes a new close only once it is through with the last one.
// A close takes longest when both averages seed on it; a close with two
// updates also runs the confidence division. Most of the time goes to the
// shared one-bit-per-cycle divider; a close that only accumulates runs no
// division. The result register lets the next close be taken while a result
// waits; the controller holds the following result until it is free.
// Reset clears both averages, seed sums, the candle count and the periods to 9/21.
module ema_crossover_detector_top
  import ecd_pkg::*;
#(
  parameter int MAX_PERIOD = DEF_MAX_PERIOD,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ecd_stream_if.sink   cfg_i,
  ecd_stream_if.sink   in_i,
  ecd_stream_if.source out_o
);

  ecd_cmd_t    cmd;
  ecd_status_t status;
  logic        in_ready;
  logic        out_valid;
  result_t     out_data;
  cfg_wr_t     cfg_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.data;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

  ecd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ecd_dpath #(
    .MAX_PERIOD (MAX_PERIOD),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_wr.index),
    .cfg_val_i   (cfg_wr.value),
    .close_i     (in_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

`ifndef SYNTHESIS
  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !status.div_busy)
    else $error("divider started while busy");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_wr |-> status.out_free)
    else $error("pending result overwritten");

  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("item taken while previous one in progress");

  a_cross_needs_warm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.data.signal != SIG_NONE)) |-> out_o.data.warmed_up)
    else $error("cross reported before both averages seeded");
`endif

endmodule

// ===== sim/ema_crossover_detector_top_test.sv =====
// Self-checking testbench for ema_crossover_detector_top: a directed table, then random
// candle phases, checked against an in-bench crossover predictor or, for typed rows, the table's result.
// Depends on ecd_pkg, ecd_stream_if and the detector RTL.
`timescale 1ns / 1ps

module ema_crossover_detector_top_test
  import ecd_pkg::*;
;

  localparam int  CLK_HALF       = 5;
  localparam int  RESET_CYCLES   = 3;
  localparam int  IDLE_PERCENT   = 13;
  localparam int  TOTAL_CLOSES   = 1900;
  localparam int  HOLD_CYCLES    = 3000;
  localparam int  HOLD_AT        = 400;
  localparam int  CALM_FROM      = 1200;
  localparam int  CALM_TO        = 1500;
  localparam int  TAIL_CYCLES    = 300;
  // bound on the whole run: the worst-case time per close for every close sent,
  // plus hold-off and drains, with margin
  localparam int  CYCLE_LIMIT    = 2_000_000;
  localparam int  MAXP           = DEF_MAX_PERIOD;
  localparam int  FRAC           = DEF_FRAC_BITS;

  // no register lives at this index; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam result_t QUIET_COLD = '{SIG_NONE, 16'd0, 32'd0, 1'b0};

  typedef enum bit {ROW_CLOSE, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [PERIOD_W-1:0]   period;
    close_t                price;
    bit                    typed;
    result_t               want;
  } plan_row_t;

  localparam int PLAN_LEN = 29;

  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_CLOSE, REG_FAST_PERIOD, 11'd0,    32'h0000_0000, 1'b1, QUIET_COLD},
    '{ROW_CLOSE, REG_FAST_PERIOD, 11'd0,    32'hFFFF_FFFF, 1'b1, QUIET_COLD},
    '{ROW_CLOSE, REG_FAST_PERIOD, 11'd0,    32'h0000_0001, 1'b1, QUIET_COLD},
    // shorten both periods while still seeding: seeds divide by closes seen
    '{ROW_CFG,   REG_FAST_PERIOD, 11'd0,    32'h0,         1'b0, QUIET_COLD},
    '{ROW_CFG,   REG_SLOW_PERIOD, 11'd2,    32'h0,         1'b0, QUIET_COLD},
    '{ROW_CLOSE, REG_FAST_PERIOD, 11'd0,    32'h8000_0000, 1'b0, QUIET_COLD},
    '{ROW_CLOSE, REG_FAST_PERIOD, 11'd0,    32'hFFFF_FFFF, 1'b0, QUIET_COLD},
    '{ROW_CLOSE, REG_FAST_PERIOD, 11'd0,    32'h0000_0000, 1'b0, QUIET_COLD},
    '{ROW_CLOSE, REG_FAST_PERIOD, 11'd0,    32'hFFFF_FFFF, 1'b0, QUIET_COLD},
    '{ROW_CLOSE, REG_FAST_PERIOD, 11'd0,    32'h0000_0000, 1'b0, QUIET_COLD},
    '{ROW_CFG,   REG_SPARE,       11'd5,    32'h0,         1'b0, QUIET_COLD},
    '{ROW_CLOSE, REG_FAST_PERIOD, 11'd0,    32'h0000_0007, 1'b0, QUIET_COLD},
    // equal periods keep the averages tied: never a cross
    '{ROW_CFG,   REG_FAST_PERIOD, 11'd1,    32'h0,         1'b0, QUIET_COLD},
    '{ROW_CFG,   REG_SLOW_PERIOD, 11'd1,    32'h0,         1'b0, QUIET_COLD},
    '{ROW_CLOSE, REG_FAST_PERIOD, 11'd0,    32'h1234_5678, 1'b0, QUIET_COLD},
    '{ROW_CLOSE, REG_FAST_PERIOD, 11'd0,    32'h1234_5678, 1'b0, QUIET_COLD},
    // break the tie: a tie followed by strict inequality is a cross
    '{ROW_CFG,   REG_SLOW_PERIOD, 11'd3,    32'h0,         1'b0, QUIET_COLD},
    '{ROW_CLOSE, REG_FAST_PERIOD, 11'd0,    32'hFFFF_FFFF, 1'b0, QUIET_COLD},
    '{ROW_CLOSE, REG_FAST_PERIOD, 11'd0,    32'h0000_0000, 1'b0, QUIET_COLD},
    // slow tracks the close exactly, so a zero close drives slow to zero
    '{ROW_CFG,   REG_FAST_PERIOD, 11'd3,    32'h0,         1'b0, QUIET_COLD},
    '{ROW_CFG,   REG_SLOW_PERIOD, 11'd1,    32'h0,         1'b0, QUIET_COLD},
    '{ROW_CLOSE, REG_FAST_PERIOD, 11'd0,    32'h0000_0064, 1'b0, QUIET_COLD},
    '{ROW_CLOSE, REG_FAST_PERIOD, 11'd0,    32'h0000_0000, 1'b0, QUIET_COLD},
    '{ROW_CLOSE, REG_FAST_PERIOD, 11'd0,    32'hFFFF_FFFF, 1'b0, QUIET_COLD},
    '{ROW_CLOSE, REG_FAST_PERIOD, 11'd0,    32'h0000_0001, 1'b0, QUIET_COLD},
    // out-of-range period clamps to the maximum
    '{ROW_CFG,   REG_FAST_PERIOD, 11'd2047, 32'h0,         1'b0, QUIET_COLD},
    '{ROW_CFG,   REG_SLOW_PERIOD, 11'd1024, 32'h0,         1'b0, QUIET_COLD},
    '{ROW_CLOSE, REG_FAST_PERIOD, 11'd0,    32'hAAAA_AAAA, 1'b0, QUIET_COLD},
    '{ROW_CLOSE, REG_FAST_PERIOD, 11'd0,    32'h5555_5555, 1'b0, QUIET_COLD}
  };

  logic clk_i;
  logic rst_ni;

  ecd_stream_if #(.T(cfg_wr_t)) cfg_if ();
  ecd_stream_if #(.T(close_t))  in_if ();
  ecd_stream_if #(.T(result_t)) out_if ();

  ema_crossover_detector_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predictor state
  logic [PERIOD_W-1:0] fast_reg = FAST_PERIOD_RST;
  logic [PERIOD_W-1:0] slow_reg = SLOW_PERIOD_RST;
  logic [10:0]         candles = '0;
  logic [41:0]         fast_sum = '0;
  logic [41:0]         slow_sum = '0;
  logic [47:0]         fast_avg = '0;
  logic [47:0]         slow_avg = '0;
  bit                  fast_seeded = 1'b0;
  bit                  slow_seeded = 1'b0;
  bit                  have_pair = 1'b0;

  result_t     due_signals [$];
  int unsigned closes_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  longint      walk_level = 64'h8000_0000;
  bit          walk_up = 1'b1;

  function automatic logic [63:0] clamp_period(input logic [PERIOD_W-1:0] p);
    if (p == '0) return 64'd1;
    if (p > MAXP) return 64'(MAXP);
    return 64'(p);
  endfunction

  task automatic track_average(input close_t x, input logic [63:0] period,
                               inout logic [41:0] sum, inout logic [47:0] avg,
                               inout bit seeded);
    logic [63:0] n, q, rem, xf, den;
    if (!seeded) begin
      sum = sum + 42'(x);
      if (64'(candles) >= period) begin
        n   = 64'(candles);
        q   = 64'(sum) / n;
        rem = 64'(sum) % n;
        avg = 48'((q << FRAC) + ((rem << FRAC) / n));
        seeded = 1'b1;
      end
    end else begin
      xf  = 64'(x) << FRAC;
      den = period + 64'd1;
      if (xf >= 64'(avg)) avg = avg + 48'(((xf - 64'(avg)) * 2) / den);
      else                avg = avg - 48'(((64'(avg) - xf) * 2) / den);
    end
  endtask

  function automatic logic [CONF_W-1:0] distance_ratio(input logic [47:0] f,
                                                       input logic [47:0] s);
    logic [63:0] d;
    if (s == '0) return '0;
    d = (f >= s) ? 64'(f - s) : 64'(s - f);
    if (d >= 64'(s)) return '1;
    return CONF_W'((d << CONF_W) / 64'(s));
  endfunction

  task automatic predict_crossover(input close_t x, output result_t r);
    logic [47:0] pf, ps;
    bit up, down;
    pf = fast_avg;
    ps = slow_avg;
    if (candles < MAXP) candles = candles + 1'b1;
    track_average(x, clamp_period(fast_reg), fast_sum, fast_avg, fast_seeded);
    track_average(x, clamp_period(slow_reg), slow_sum, slow_avg, slow_seeded);
    r = QUIET_COLD;
    if (fast_seeded && slow_seeded) begin
      r.warmed_up = 1'b1;
      if (have_pair) begin
        up   = (pf <= ps) && (fast_avg > slow_avg);
        down = (pf >= ps) && (fast_avg < slow_avg);
        if (up || down) begin
          r.signal       = up ? SIG_BUY : SIG_SELL;
          r.confidence   = distance_ratio(fast_avg, slow_avg);
          r.signal_price = x;
        end
      end
      have_pair = 1'b1;
    end
  endtask

  // Mostly a trending walk so the averages cross; the rest full-range noise
  // and the extremes.
  function automatic close_t next_close();
    int unsigned pick;
    longint stepv;
    pick = $urandom_range(99);
    if (pick < 8) return $urandom_range(1) ? {CLOSE_W{1'b1}} : '0;
    if (pick < 25) return close_t'($urandom());
    if ($urandom_range(9) == 0) walk_up = !walk_up;
    stepv = longint'($urandom_range(32'd1 << $urandom_range(2, 26)));
    if (walk_up ^ ($urandom_range(3) == 0)) walk_level = walk_level + stepv;
    else                                    walk_level = walk_level - stepv;
    if (walk_level < 0) walk_level = 0;
    if (walk_level > 64'hFFFF_FFFF) walk_level = 64'hFFFF_FFFF;
    return close_t'(walk_level);
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5)  return '0;
    if (pick < 8)  return 11'd1024;
    if (pick < 10) return '1;
    if (pick < 13) return 11'($urandom_range(1025, 2047));
    if (pick < 17) return 11'($urandom_range(1, 1024));
    return 11'($urandom_range(1, 24));
  endfunction

  task automatic offer_close(input close_t x, input bit typed, input result_t typed_want);
    int unsigned gap;
    result_t want;
    gap = 0;
    if (!calm) while ($urandom_range(99) < IDLE_PERCENT) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= x;
    do @(posedge clk_i); while (!in_if.ready);
    predict_crossover(x, want);
    due_signals.insert(due_signals.size(), typed ? typed_want : want);
    closes_sent++;
  endtask

  task automatic write_period(input logic [CFG_IDX_W-1:0] idx,
                              input logic [PERIOD_W-1:0] val, input bit last);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{idx, val};
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == REG_FAST_PERIOD) fast_reg = val;
    else if (idx == REG_SLOW_PERIOD) slow_reg = val;
    if (last) cfg_if.valid <= 1'b0;
  endtask

  // drop valid and hold until every outstanding result has been taken
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (due_signals.size() != 0);
  endtask

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request, calm stretch
  always @(posedge clk_i) begin
    bit take;
    if (hold_left > 0) begin
      hold_left--;
      take = 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      take      = 1'b0;
    end else begin
      take = calm || ($urandom_range(99) >= IDLE_PERCENT);
    end
    out_if.ready <= take;
  end

  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (due_signals.size() == 0) begin
        $error("unexpected result: signal %0d price %0h", got.signal, got.signal_price);
        mismatches++;
      end else begin
        want = due_signals.pop_front();
        if (got.signal != want.signal) begin
          $error("signal: expected %0d, got %0d", want.signal, got.signal);
          mismatches++;
        end
        if (got.confidence != want.confidence) begin
          $error("confidence: expected %0d, got %0d", want.confidence, got.confidence);
          mismatches++;
        end
        if (got.signal_price != want.signal_price) begin
          $error("signal_price: expected %0h, got %0h", want.signal_price,
                 got.signal_price);
          mismatches++;
        end
        if (got.warmed_up != want.warmed_up) begin
          $error("warmed_up: expected %0d, got %0d", want.warmed_up, got.warmed_up);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned phase_len;
    bit          fast_first;
    bit          last_cfg;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        if (i == 0 || plan[i-1].kind != ROW_CFG) wait_drained();
        last_cfg = (i == PLAN_LEN - 1) || (plan[i+1].kind != ROW_CFG);
        write_period(plan[i].index, plan[i].period, last_cfg);
      end else begin
        offer_close(plan[i].price, plan[i].typed, plan[i].want);
      end
    end

    while (closes_sent < TOTAL_CLOSES) begin
      wait_drained();
      if ($urandom_range(3) == 0) write_period(REG_SPARE, 11'($urandom_range(2047)), 1'b0);
      fast_first = $urandom_range(1);
      if (fast_first) begin
        write_period(REG_FAST_PERIOD, pick_period(), 1'b0);
        write_period(REG_SLOW_PERIOD, pick_period(), 1'b1);
      end else begin
        write_period(REG_SLOW_PERIOD, pick_period(), 1'b0);
        write_period(REG_FAST_PERIOD, pick_period(), 1'b1);
      end
      phase_len = $urandom_range(40, 140);
      repeat (phase_len) begin
        calm = (closes_sent >= CALM_FROM) && (closes_sent < CALM_TO);
        if (closes_sent == HOLD_AT) hold_req = 1'b1;
        offer_close(next_close(), 1'b0, QUIET_COLD);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && due_signals.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
